FILE: rtl/stepper_ramp_controller_unit_macros.svh
// Assertion macros for the stepper ramp controller top level.
`ifndef STEPPER_RAMP_CONTROLLER_UNIT_MACROS_SVH
`define STEPPER_RAMP_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SRCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SRCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srcu_pkg.sv
// Types and constants shared by the stepper ramp controller modules.
`timescale 1ns / 1ps

package srcu_pkg;

  localparam int unsigned SlowW = 16;
  localparam int unsigned RampW = 12;
  localparam int unsigned PosW  = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ProdW = SlowW + RampW;

  // The quotient of the interpolation always fits the delay width.
  localparam int unsigned DivSteps = SlowW;
  localparam int unsigned CntW     = $clog2(DivSteps);

  localparam logic [SlowW-1:0] SlowReset = 16'd2000;
  localparam logic [SlowW-1:0] FastReset = 16'd400;
  localparam logic [RampW-1:0] RampReset = 12'd16;

  // Configuration register indexes.
  localparam logic [1:0] RegSlowDelay = 2'd0;
  localparam logic [1:0] RegFastDelay = 2'd1;
  localparam logic [1:0] RegRampSteps = 2'd2;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StEval  = 7'b0000010,
    StRange = 7'b0000100,
    StMul   = 7'b0001000,
    StDiv   = 7'b0010000,
    StFin   = 7'b0100000,
    StPush  = 7'b1000000
  } srcu_state_e;

  typedef struct packed {
    logic latch;
    logic eval;
    logic range;
    logic mul;
    logic div_step;
    logic fin;
    logic push;
  } srcu_cmd_t;

  typedef struct packed {
    logic step_ok;
    logic in_range;
  } srcu_sts_t;

endpackage

FILE: rtl/stepper_ramp_controller_unit.sv
// Stepper ramp controller top level: step and direction drive with a linear step-delay ramp.
`timescale 1ns / 1ps
`include "stepper_ramp_controller_unit_macros.svh"

// Each input transaction either loads a new goal position (mode 1) or presents
// the current microsecond time (mode 0), and produces exactly one result
// transaction with the step pulse, the direction level and the position.
// A goal transaction, or a time transaction that does not step, passes from
// acceptance through the evaluate and push states before the next transaction
// can be accepted. A step taken outside the ramp adds the range state, which
// loads the fast delay directly. A step inside the ramp also passes the multiply,
// divide and finish states: the next step interval is interpolated with one
// 16 by 12 bit multiply and a restoring divider by the ramp length. Every path
// waits in the push state while a previous result is held in the output register
// under stall. Configuration writes are always taken and apply from the next
// interval computed.
module stepper_ramp_controller_unit import srcu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    mode_i,
  input  logic        [TimeW-1:0] now_us_i,
  input  logic signed [PosW-1:0]  target_position_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    step_pulse_o,
  output logic                    direction_o,
  output logic signed [PosW-1:0]  position_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic        [1:0]       cfg_index_i,
  input  logic        [SlowW-1:0] cfg_data_i
);

  srcu_cmd_t cmd;
  srcu_sts_t sts;

  assign cfg_ready_o = 1'b1;

  srcu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srcu_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .now_us_i         (now_us_i),
    .target_position_i(target_position_i),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .step_pulse_o     (step_pulse_o),
    .direction_o      (direction_o),
    .position_o       (position_o)
  );

  // The unit works on one transaction at a time.
  `SRCU_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken while a transaction is in flight")

  // A fresh result is loaded only as the sequencer returns to idle.
  `SRCU_ASSERT_IMP(a_result_at_idle, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o, "result appeared while the sequencer was busy")

  // A step toward higher positions can never land on the lowest position.
  `SRCU_ASSERT_IMP(a_up_step_range, clk_i, rst_ni, out_valid_o && step_pulse_o && direction_o, position_o != 16'sh8000, "upward step reported at the lowest position")

endmodule

FILE: rtl/srcu_ctrl.sv
// Sequencer of the stepper ramp controller: handshakes and datapath commands.
`timescale 1ns / 1ps

module srcu_ctrl import srcu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  srcu_sts_t sts_i,
  output srcu_cmd_t cmd_o
);

  srcu_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.step_ok ? StRange : StPush;
      end
      StRange: begin
        cmd_o.range = 1'b1;
        state_d     = sts_i.in_range ? StMul : StPush;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StPush;
      end
      StPush: begin
        // The result register must be empty or draining this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.push = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_d = cmd_o.push | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/srcu_dp.sv
// Datapath of the stepper ramp controller: position, timing and ramp divider.
`timescale 1ns / 1ps

module srcu_dp import srcu_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srcu_cmd_t               cmd_i,
  output srcu_sts_t               sts_o,
  input  logic                    mode_i,
  input  logic        [TimeW-1:0] now_us_i,
  input  logic signed [PosW-1:0]  target_position_i,
  input  logic                    cfg_we_i,
  input  logic        [1:0]       cfg_index_i,
  input  logic        [SlowW-1:0] cfg_data_i,
  output logic                    step_pulse_o,
  output logic                    direction_o,
  output logic signed [PosW-1:0]  position_o
);

  // Configuration and motion state.
  logic        [SlowW-1:0] slow_q, fast_q, intv_q;
  logic        [RampW-1:0] ramp_q;
  logic signed [PosW-1:0]  cur_q, goal_q;
  logic        [TimeW-1:0] last_q;
  logic                    dir_q;

  // Latched transaction and working registers.
  logic                    mode_q;
  logic        [TimeW-1:0] now_q;
  logic signed [PosW-1:0]  target_q;
  logic                    pulse_q;
  logic        [RampW-1:0] rpos_q;
  logic        [SlowW-1:0] span_q;
  logic        [ProdW-1:0] prod_q;

  logic                    out_pulse_q, out_dir_q;
  logic signed [PosW-1:0]  out_pos_q;

  logic        [TimeW-1:0] elapsed;
  logic                    step_ok, step_up;
  logic signed [PosW:0]    gap;
  logic        [PosW:0]    gap_abs;
  logic        [PosW-1:0]  to_go, taken, rpos;
  logic        [SlowW-1:0] fast_eff, span;
  logic                    in_range;
  logic        [RampW:0]   trial, trial_sub;
  logic                    fits;

  always_comb begin
    elapsed = now_q - last_q;
    step_ok = !mode_q && (elapsed >= TimeW'(intv_q)) && (cur_q != goal_q);
    step_up = goal_q > cur_q;

    gap      = $signed({goal_q[PosW-1], goal_q}) - $signed({cur_q[PosW-1], cur_q});
    gap_abs  = gap[PosW] ? (PosW+1)'(-gap) : gap;
    to_go    = gap_abs[PosW-1:0];
    taken    = cur_q[PosW-1] ? PosW'(-cur_q) : cur_q;
    rpos     = (taken < to_go) ? taken : to_go;
    in_range = rpos < PosW'(ramp_q);
    fast_eff = (fast_q > slow_q) ? slow_q : fast_q;
    span     = slow_q - fast_eff;

    // One restoring division step; the upper part always stays below the ramp length.
    trial     = {prod_q[ProdW-1:SlowW], prod_q[SlowW-1]};
    fits      = trial >= {1'b0, ramp_q};
    trial_sub = trial - {1'b0, ramp_q};
  end

  assign sts_o.step_ok  = step_ok;
  assign sts_o.in_range = in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q <= SlowReset;
      fast_q <= FastReset;
      ramp_q <= RampReset;
      cur_q  <= '0;
      goal_q <= '0;
      last_q <= '0;
      intv_q <= SlowReset;
      dir_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegSlowDelay: slow_q <= cfg_data_i;
          RegFastDelay: fast_q <= cfg_data_i;
          RegRampSteps: ramp_q <= cfg_data_i[RampW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.eval) begin
        if (mode_q) begin
          goal_q <= target_q;
        end else if (step_ok) begin
          dir_q  <= step_up;
          cur_q  <= step_up ? cur_q + 1'b1 : cur_q - 1'b1;
          last_q <= now_q;
        end
      end
      if (cmd_i.range && !in_range) begin
        intv_q <= fast_eff;
      end
      if (cmd_i.fin) begin
        intv_q <= slow_q - prod_q[SlowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q   <= mode_i;
      now_q    <= now_us_i;
      target_q <= target_position_i;
    end
    if (cmd_i.eval) begin
      pulse_q <= step_ok;
    end
    if (cmd_i.range) begin
      rpos_q <= rpos[RampW-1:0];
      span_q <= span;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(span_q) * ProdW'(rpos_q);
    end else if (cmd_i.div_step) begin
      prod_q <= {(fits ? trial_sub[RampW-1:0] : trial[RampW-1:0]),
                 prod_q[SlowW-2:0], fits};
    end
    if (cmd_i.push) begin
      out_pulse_q <= pulse_q;
      out_dir_q   <= dir_q;
      out_pos_q   <= cur_q;
    end
  end

  assign step_pulse_o = out_pulse_q;
  assign direction_o  = out_dir_q;
  assign position_o   = out_pos_q;

endmodule
